// ===== sv/tpt_pkg.sv =====
`default_nettype none
package tpt_pkg;

    localparam int ACCEL_FRAC_BITS_DEF = 12;
    localparam int GAIN_FRAC_BITS_DEF  = 8;
    localparam int DRIVE_MAX_DEF       = 255;

    // command codes carried in tuser
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_START_Y = 2'd1;
    localparam logic [1:0] CMD_START_X = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_Y_ACCEL     = 3'd0;
    localparam logic [2:0] REG_Y_SPEED     = 3'd1;
    localparam logic [2:0] REG_Y_DISTANCE  = 3'd2;
    localparam logic [2:0] REG_Y_DIRECTION = 3'd3;
    localparam logic [2:0] REG_X_SPEED     = 3'd4;
    localparam logic [2:0] REG_X_DISTANCE  = 3'd5;

    localparam logic [15:0] Y_ACCEL_RST = 16'd819;
    localparam logic [7:0]  Y_SPEED_RST = 8'd30;
    localparam logic [7:0]  X_SPEED_RST = 8'd10;

    // PID gains rounded to Q.gfb
    function automatic int gain_xp(input int gfb);
        return 4 * (1 << gfb);
    endfunction
    function automatic int gain_xi(input int gfb);
        return (2 * (1 << gfb) + 5) / 10;
    endfunction
    function automatic int gain_xd(input int gfb);
        return 5 * (1 << gfb);
    endfunction
    function automatic int gain_yp(input int gfb);
        return (4 * (1 << gfb) + 5) / 10;
    endfunction
    function automatic int gain_yi(input int gfb);
        return ((1 << gfb) + 10) / 20;
    endfunction
    function automatic int gain_yd(input int gfb);
        return 3 * (1 << gfb);
    endfunction

endpackage
`default_nettype wire

// ===== sv/tpt_mul.sv =====
`default_nettype none
module tpt_mul #(
    parameter int A_W = 34,
    parameter int B_W = 21
) (
    input  wire                          i_clk,
    input  wire  signed [A_W-1:0]        i_a,
    input  wire  signed [B_W-1:0]        i_b,
    output logic signed [A_W+B_W-1:0]    o_p
);
    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== sv/tpt_div.sv =====
`default_nettype none
module tpt_div #(
    parameter int DVD_W = 36,
    parameter int DVS_W = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire  [DVD_W-1:0] i_dividend,
    input  wire  [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   w_sh;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_sh   = {r_rem, r_quo[DVD_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_ge   = w_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DVD_W);
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            // one quotient bit per cycle, restoring
            r_cnt <= r_cnt - 1'b1;
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ===== sv/tpt_sqrt.sv =====
`default_nettype none
module tpt_sqrt #(
    parameter int IN_W = 36
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [IN_W-1:0]   i_value,
    output logic              o_busy,
    output logic [IN_W/2-1:0] o_root
);
    localparam int RT_W  = IN_W / 2;
    localparam int SH_W  = RT_W + 3;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [IN_W-1:0]  r_x;
    logic [SH_W-1:0]  r_rem;
    logic [RT_W-1:0]  r_root;
    logic [SH_W-1:0]  w_sh;
    logic [SH_W-1:0]  w_trial;
    logic             w_ge;

    assign w_sh    = {r_rem[SH_W-3:0], r_x[IN_W-1:IN_W-2]};
    assign w_trial = SH_W'({r_root, 2'b01});
    assign w_ge    = w_sh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(RT_W);
            r_x    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            // one root bit per cycle from the next bit pair
            r_cnt  <= r_cnt - 1'b1;
            r_x    <= {r_x[IN_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_sh - w_trial) : w_sh;
            r_root <= {r_root[RT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== sv/trapezoid_profile_pid_tracker_top.sv =====
// Channel  Dir  Handshake                         Payload
// s_axis   in   i_s_axis_tvalid / o_s_axis_tready  tuser command, tdata y_count, x_count
// m_axis   out  o_m_axis_tvalid / i_m_axis_tready  tdata drives and status flags
// cfg      in   i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//
// One request at a time; ready is low until its result is loaded in the output register.
// Y start: one product, three restoring divides (24+F bits) and one root for a trapezoid;
// two products, two divides and one root for a triangle. X start: one divide. Tick: products
// on the shared multiplier. Unknown command, idle tick: straight to the output register.
// Synchronous active-low reset clears control, configuration and tracker registers, not the
// work registers or output data; no clearing pass. Config taken when idle.
// A result waiting on o_m_axis_tready holds the next result in its last step.
`default_nettype none
module trapezoid_profile_pid_tracker_top #(
    parameter int ACCEL_FRAC_BITS = tpt_pkg::ACCEL_FRAC_BITS_DEF,
    parameter int GAIN_FRAC_BITS  = tpt_pkg::GAIN_FRAC_BITS_DEF,
    parameter int DRIVE_MAX       = tpt_pkg::DRIVE_MAX_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [39:0] i_s_axis_tdata,  // y_count[23:0], x_count[39:24]
    input  wire  [1:0]  i_s_axis_tuser,  // command[1:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // y_drive[7:0], x_drive[15:8], y_busy[16], x_busy[17], x_reverse[18],
    // y_dir_pin[19], clear_counts[20], zero[23:21]
    output logic [23:0] o_m_axis_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data
);
    localparam int F     = ACCEL_FRAC_BITS;
    localparam int G     = GAIN_FRAC_BITS;
    localparam int DIV_W = 24 + F;
    localparam int SQ_W  = DIV_W + (DIV_W % 2);
    localparam int RT_W  = SQ_W / 2;
    localparam int PK_W  = 8 + F;
    localparam int MA_W  = 34;
    localparam int MB_W  = PK_W + 1;
    localparam int P_W   = MA_W + MB_W;
    localparam int AC_W  = P_W + 2;
    localparam int E_W   = P_W + 2;
    localparam int DR_W  = $clog2(DRIVE_MAX + 1);
    localparam int K_W   = G + 4;

    localparam logic [K_W-1:0]  XP_K = K_W'(tpt_pkg::gain_xp(G));
    localparam logic [K_W-1:0]  XI_K = K_W'(tpt_pkg::gain_xi(G));
    localparam logic [K_W-1:0]  XD_K = K_W'(tpt_pkg::gain_xd(G));
    localparam logic [K_W-1:0]  YP_K = K_W'(tpt_pkg::gain_yp(G));
    localparam logic [K_W-1:0]  YI_K = K_W'(tpt_pkg::gain_yi(G));
    localparam logic [K_W-1:0]  YD_K = K_W'(tpt_pkg::gain_yd(G));
    localparam logic [DR_W-1:0] DMAX = DR_W'(DRIVE_MAX);

    typedef enum logic [4:0] {
        ST_IDLE, ST_WAIT,
        ST_YS0, ST_YS1, ST_YS2, ST_YS3, ST_YS4, ST_YS5, ST_YS6,
        ST_XS0, ST_XS1,
        ST_YT0, ST_YT1, ST_YU1, ST_YU2, ST_YC1, ST_YD1, ST_YD2, ST_YPID,
        ST_XCHK, ST_XT0, ST_XT1, ST_XT2,
        ST_P0, ST_P1, ST_P2, ST_P3,
        ST_OUT
    } t_state;

    t_state r_state, r_ret;

    // configuration
    logic [15:0]        r_y_accel;
    logic [7:0]         r_y_speed;
    logic [23:0]        r_y_dist;
    logic               r_y_dir;
    logic [7:0]         r_x_speed;
    logic signed [15:0] r_x_dist;

    // request
    logic [23:0]        r_ycnt;
    logic signed [15:0] r_xcnt;

    // tracker state
    logic [17:0]        r_tick;
    logic signed [31:0] r_integ;
    logic signed [15:0] r_prev_ye, r_prev_xe;
    logic [15:0]        r_t1, r_t2, r_xt;
    logic [23:0]        r_rd, r_cd;
    logic [PK_W-1:0]    r_peak;
    logic               r_ybusy, r_xbusy, r_xrev, r_ydir_pin;
    logic [DR_W-1:0]    r_ydrive, r_xdrive;

    // work registers
    logic signed [MA_W-1:0] r_ma;
    logic signed [MB_W-1:0] r_mb;
    logic [DIV_W-1:0]       r_dvd;
    logic [15:0]            r_dvs;
    logic [SQ_W-1:0]        r_sqin;
    logic                   r_go_div, r_go_sqrt;
    logic                   r_trap;
    logic signed [P_W:0]    r_ideal;
    logic signed [15:0]     r_e;
    logic                   r_axis_x;
    logic signed [AC_W-1:0] r_acc;
    logic                   r_clr;
    logic                   r_ovalid;
    logic [23:0]            r_odata;

    logic signed [P_W-1:0] w_p;
    logic [DIV_W-1:0]      w_quo;
    logic [RT_W-1:0]       w_root;
    logic                  w_div_busy, w_sqrt_busy;

    tpt_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
        .i_clk (i_clk), .i_a (r_ma), .i_b (r_mb), .o_p (w_p)
    );

    tpt_div #(.DVD_W(DIV_W), .DVS_W(16)) u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_go_div),
        .i_dividend (r_dvd), .i_divisor (r_dvs),
        .o_busy (w_div_busy), .o_quotient (w_quo)
    );

    tpt_sqrt #(.IN_W(SQ_W)) u_sqrt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_go_sqrt),
        .i_value (r_sqin), .o_busy (w_sqrt_busy), .o_root (w_root)
    );

    function automatic logic signed [15:0] sat_e(input logic signed [E_W-1:0] v);
        if (v > E_W'(32767))        return 16'sh7FFF;
        else if (v < -E_W'(32768))  return 16'sh8000;
        else                        return 16'(v);
    endfunction

    function automatic logic [15:0] sat16(input logic [DIV_W-1:0] v);
        return (v > DIV_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
    endfunction

    // zero-clamped divisors for planning
    logic [15:0] w_a1;
    logic [7:0]  w_v1, w_s1;
    assign w_a1 = (r_y_accel == '0) ? 16'd1 : r_y_accel;
    assign w_v1 = (r_y_speed == '0) ? 8'd1 : r_y_speed;
    assign w_s1 = (r_x_speed == '0) ? 8'd1 : r_x_speed;

    logic [DIV_W:0] w_r2;
    logic           w_trap;
    logic [15:0]    w_rt;
    logic [15:0]    w_xmag;
    assign w_r2   = {w_quo, 1'b0};
    assign w_trap = (DIV_W + 1)'(r_y_dist) > w_r2;
    assign w_rt   = (w_root > RT_W'(16'hFFFF)) ? 16'hFFFF : w_root[15:0];
    assign w_xmag = r_x_dist[15] ? (~r_x_dist + 16'd1) : r_x_dist;

    // profile phase boundaries
    logic [18:0] w_t, w_lim1, w_lim2, w_lim3;
    logic [17:0] w_tc;
    logic [15:0] w_d;
    assign w_t    = {1'b0, r_tick};
    assign w_lim1 = 19'(r_t1);
    assign w_lim2 = 19'(r_t1) + 19'(r_t2);
    assign w_lim3 = w_lim2 + 19'(r_t1);
    assign w_tc   = r_tick - 18'(r_t1);
    assign w_d    = 16'(r_tick - 18'(r_t1) - 18'(r_t2));

    logic signed [P_W-1:0] w_term;
    logic signed [E_W-1:0] w_yerr, w_xerr;
    assign w_term = w_p[P_W-1] ? '0 : w_p;
    assign w_yerr = E_W'(r_ideal) - E_W'($signed({1'b0, r_ycnt}));
    assign w_xerr = r_xrev ? (E_W'(w_p) + E_W'(r_xcnt)) : (E_W'(w_p) - E_W'(r_xcnt));

    // PID datapath
    logic signed [32:0]     w_isum;
    logic signed [31:0]     w_isat;
    logic [K_W-1:0]         w_ki, w_kp, w_kd;
    logic signed [15:0]     w_prev;
    logic signed [16:0]     w_ediff;
    logic signed [AC_W-1:0] w_sum, w_shr;
    logic [DR_W-1:0]        w_drive;
    assign w_isum  = 33'(r_integ) + 33'(r_e);
    assign w_isat  = (w_isum[32] != w_isum[31]) ?
                     (w_isum[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : w_isum[31:0];
    assign w_ki    = r_axis_x ? XI_K : YI_K;
    assign w_kp    = r_axis_x ? XP_K : YP_K;
    assign w_kd    = r_axis_x ? XD_K : YD_K;
    assign w_prev  = r_axis_x ? r_prev_xe : r_prev_ye;
    assign w_ediff = 17'(r_e) - 17'(w_prev);
    assign w_sum   = r_acc + AC_W'(w_p);
    assign w_shr   = w_sum >>> G;
    assign w_drive = w_sum[AC_W-1] ? '0 :
                     ((w_shr > AC_W'(DRIVE_MAX)) ? DMAX : DR_W'(w_shr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ret      <= ST_IDLE;
            r_y_accel  <= tpt_pkg::Y_ACCEL_RST;
            r_y_speed  <= tpt_pkg::Y_SPEED_RST;
            r_y_dist   <= '0;
            r_y_dir    <= 1'b0;
            r_x_speed  <= tpt_pkg::X_SPEED_RST;
            r_x_dist   <= '0;
            r_tick     <= '0;
            r_integ    <= '0;
            r_prev_ye  <= '0;
            r_prev_xe  <= '0;
            r_t1       <= '0;
            r_t2       <= '0;
            r_xt       <= '0;
            r_rd       <= '0;
            r_cd       <= '0;
            r_peak     <= '0;
            r_ybusy    <= 1'b0;
            r_xbusy    <= 1'b0;
            r_xrev     <= 1'b0;
            r_ydir_pin <= 1'b0;
            r_ydrive   <= '0;
            r_xdrive   <= '0;
            r_go_div   <= 1'b0;
            r_go_sqrt  <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tpt_pkg::REG_Y_ACCEL:     r_y_accel <= i_cfg_data[15:0];
                    tpt_pkg::REG_Y_SPEED:     r_y_speed <= i_cfg_data[7:0];
                    tpt_pkg::REG_Y_DISTANCE:  r_y_dist  <= i_cfg_data;
                    tpt_pkg::REG_Y_DIRECTION: r_y_dir   <= i_cfg_data[0];
                    tpt_pkg::REG_X_SPEED:     r_x_speed <= i_cfg_data[7:0];
                    tpt_pkg::REG_X_DISTANCE:  r_x_dist  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // ST_OUT reloads the output register itself
            if (r_ovalid && i_m_axis_tready && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_ycnt <= i_s_axis_tdata[23:0];
                        r_xcnt <= i_s_axis_tdata[39:24];
                        r_clr  <= 1'b0;
                        case (i_s_axis_tuser)
                            tpt_pkg::CMD_START_Y: r_state <= ST_YS0;
                            tpt_pkg::CMD_START_X: r_state <= ST_XS0;
                            tpt_pkg::CMD_TICK: begin
                                if (r_ybusy)      r_state <= ST_YT0;
                                else if (r_xbusy) r_state <= ST_XT0;
                                else              r_state <= ST_OUT;
                            end
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_WAIT: begin
                    // drop the start pulse, then hold until the unit is done
                    if (r_go_div || r_go_sqrt) begin
                        r_go_div  <= 1'b0;
                        r_go_sqrt <= 1'b0;
                    end else if (!w_div_busy && !w_sqrt_busy) begin
                        r_state <= r_ret;
                    end
                end
                ST_YS0: begin
                    r_ma    <= MA_W'($signed({1'b0, w_v1}));
                    r_mb    <= MB_W'($signed({1'b0, w_v1}));
                    r_ret   <= ST_YS1;
                    r_state <= ST_WAIT;
                end
                ST_YS1: begin
                    r_dvd    <= DIV_W'({w_p[15:0], {(F - 1){1'b0}}});
                    r_dvs    <= w_a1;
                    r_go_div <= 1'b1;
                    r_ret    <= ST_YS2;
                    r_state  <= ST_WAIT;
                end
                ST_YS2: begin
                    r_trap <= w_trap;
                    if (w_trap) begin
                        r_rd  <= w_quo[23:0];
                        r_cd  <= r_y_dist - w_r2[23:0];
                        r_dvd <= {w_r2[23:0], {F{1'b0}}};
                    end else begin
                        r_rd  <= r_y_dist >> 1;
                        r_cd  <= '0;
                        r_t2  <= '0;
                        r_dvd <= {r_y_dist, {F{1'b0}}};
                    end
                    r_dvs    <= w_a1;
                    r_go_div <= 1'b1;
                    r_ret    <= ST_YS3;
                    r_state  <= ST_WAIT;
                end
                ST_YS3: begin
                    r_sqin    <= SQ_W'(w_quo);
                    r_go_sqrt <= 1'b1;
                    r_ret     <= ST_YS4;
                    r_state   <= ST_WAIT;
                end
                ST_YS4: begin
                    r_t1 <= w_rt;
                    if (r_trap) begin
                        r_peak   <= {w_v1, {F{1'b0}}};
                        r_dvd    <= DIV_W'(r_cd);
                        r_dvs    <= 16'(w_v1);
                        r_go_div <= 1'b1;
                        r_ret    <= ST_YS5;
                    end else begin
                        r_ma  <= MA_W'($signed({1'b0, w_a1}));
                        r_mb  <= MB_W'($signed({1'b0, w_rt}));
                        r_ret <= ST_YS6;
                    end
                    r_state <= ST_WAIT;
                end
                ST_YS5, ST_YS6: begin
                    if (r_state == ST_YS5) r_t2   <= sat16(w_quo);
                    else                   r_peak <= PK_W'(w_p);
                    r_tick   <= '0;
                    r_integ  <= '0;
                    r_ydrive <= '0;
                    r_ybusy  <= 1'b1;
                    if (r_y_dir) r_ydir_pin <= 1'b1;
                    r_clr    <= 1'b1;
                    r_state  <= ST_OUT;
                end
                ST_XS0: begin
                    r_dvd    <= DIV_W'(w_xmag);
                    r_dvs    <= 16'(w_s1);
                    r_go_div <= 1'b1;
                    r_ret    <= ST_XS1;
                    r_state  <= ST_WAIT;
                end
                ST_XS1: begin
                    r_xt     <= w_quo[15:0];
                    r_xrev   <= r_x_dist[15];
                    r_tick   <= '0;
                    r_integ  <= '0;
                    r_xdrive <= '0;
                    r_xbusy  <= 1'b1;
                    r_clr    <= 1'b1;
                    r_state  <= ST_OUT;
                end
                ST_YT0: begin
                    r_tick  <= r_tick + 18'd1;
                    r_state <= ST_YT1;
                end
                ST_YT1: begin
                    if (w_t < w_lim1) begin
                        r_ma    <= MA_W'($signed({1'b0, r_tick}));
                        r_mb    <= MB_W'($signed({1'b0, r_y_accel}));
                        r_ret   <= ST_YU1;
                        r_state <= ST_WAIT;
                    end else if (w_t < w_lim2) begin
                        r_ma    <= MA_W'($signed({1'b0, w_tc}));
                        r_mb    <= MB_W'($signed({1'b0, r_peak}));
                        r_ret   <= ST_YC1;
                        r_state <= ST_WAIT;
                    end else if (w_t < w_lim3) begin
                        r_ma    <= MA_W'($signed({1'b0, w_d}));
                        r_mb    <= MB_W'($signed({1'b0, r_y_accel}));
                        r_ret   <= ST_YD1;
                        r_state <= ST_WAIT;
                    end else begin
                        r_ybusy  <= 1'b0;
                        r_ydrive <= '0;
                        r_clr    <= 1'b1;
                        r_state  <= ST_XCHK;
                    end
                end
                ST_YU1: begin
                    r_ma    <= MA_W'(w_p);
                    r_mb    <= MB_W'($signed({1'b0, r_tick[15:0]}));
                    r_ret   <= ST_YU2;
                    r_state <= ST_WAIT;
                end
                ST_YU2: begin
                    r_ideal <= (P_W + 1)'(w_p >>> (F + 1));
                    r_state <= ST_YPID;
                end
                ST_YC1: begin
                    r_ideal <= (P_W + 1)'($signed({1'b0, r_rd})) + (P_W + 1)'(w_p >>> F);
                    r_state <= ST_YPID;
                end
                ST_YD1: begin
                    r_ma    <= MA_W'($signed({1'b0, r_peak, 1'b0})) - MA_W'(w_p);
                    r_mb    <= MB_W'($signed({1'b0, w_d}));
                    r_ret   <= ST_YD2;
                    r_state <= ST_WAIT;
                end
                ST_YD2: begin
                    r_ideal <= (P_W + 1)'($signed({1'b0, r_rd}))
                             + (P_W + 1)'($signed({1'b0, r_cd}))
                             + (P_W + 1)'(w_term >>> (F + 1));
                    r_state <= ST_YPID;
                end
                ST_YPID: begin
                    r_e      <= sat_e(w_yerr);
                    r_axis_x <= 1'b0;
                    r_state  <= ST_P0;
                end
                ST_XCHK: begin
                    r_state <= r_xbusy ? ST_XT0 : ST_OUT;
                end
                ST_XT0: begin
                    r_tick  <= r_tick + 18'd1;
                    r_state <= ST_XT1;
                end
                ST_XT1: begin
                    if (r_tick >= 18'(r_xt)) begin
                        r_xbusy  <= 1'b0;
                        r_xdrive <= '0;
                        r_state  <= ST_OUT;
                    end else begin
                        r_ma    <= MA_W'($signed({1'b0, r_tick}));
                        r_mb    <= MB_W'($signed({1'b0, w_s1}));
                        r_ret   <= ST_XT2;
                        r_state <= ST_WAIT;
                    end
                end
                ST_XT2: begin
                    r_e      <= sat_e(w_xerr);
                    r_axis_x <= 1'b1;
                    r_state  <= ST_P0;
                end
                ST_P0: begin
                    r_integ <= w_isat;
                    r_ma    <= MA_W'(w_isat);
                    r_mb    <= MB_W'($signed({1'b0, w_ki}));
                    r_ret   <= ST_P1;
                    r_state <= ST_WAIT;
                end
                ST_P1: begin
                    r_acc   <= AC_W'(w_p);
                    r_ma    <= MA_W'(r_e);
                    r_mb    <= MB_W'($signed({1'b0, w_kp}));
                    r_ret   <= ST_P2;
                    r_state <= ST_WAIT;
                end
                ST_P2: begin
                    r_acc   <= w_sum;
                    r_ma    <= MA_W'(w_ediff);
                    r_mb    <= MB_W'($signed({1'b0, w_kd}));
                    r_ret   <= ST_P3;
                    r_state <= ST_WAIT;
                end
                ST_P3: begin
                    if (r_axis_x) begin
                        r_prev_xe <= r_e;
                        r_xdrive  <= w_drive;
                        r_state   <= ST_OUT;
                    end else begin
                        r_prev_ye <= r_e;
                        r_ydrive  <= w_drive;
                        r_state   <= ST_XCHK;
                    end
                end
                ST_OUT: begin
                    // hold while the previous result is still waiting
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_odata  <= {3'b000, r_clr, r_ydir_pin, r_xrev, r_xbusy, r_ybusy,
                                     8'(r_xdrive), 8'(r_ydrive)};
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = r_state == ST_IDLE;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    // hold configuration writes while a request is being worked on
    assign o_cfg_ready     = r_state == ST_IDLE;

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("new request taken while one is in progress");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_busy && w_sqrt_busy))
        else $error("divider and root unit busy together");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ydrive <= DMAX) && (r_xdrive <= DMAX))
        else $error("drive above limit");

    a_y_idle_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ybusy |-> (r_ydrive == '0))
        else $error("Y drive nonzero with no move running");

    a_x_idle_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_xbusy |-> (r_xdrive == '0))
        else $error("X drive nonzero with no move running");

endmodule
`default_nettype wire

// ===== tb/tb_trapezoid_profile_pid_tracker_top.sv =====
`timescale 1ns / 100ps
module tb_trapezoid_profile_pid_tracker_top;

    localparam int  AFB = tpt_pkg::ACCEL_FRAC_BITS_DEF;
    localparam int  GFB = tpt_pkg::GAIN_FRAC_BITS_DEF;
    localparam int  DMAX = tpt_pkg::DRIVE_MAX_DEF;
    localparam longint KXP = 4 * (1 << GFB);
    localparam longint KXI = (2 * (1 << GFB) + 5) / 10;
    localparam longint KXD = 5 * (1 << GFB);
    localparam longint KYP = (4 * (1 << GFB) + 5) / 10;
    localparam longint KYI = ((1 << GFB) + 10) / 20;
    localparam longint KYD = 3 * (1 << GFB);
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  RANDOM_ITEMS = 550;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    trapezoid_profile_pid_tracker_top DUT (.*);

    always #1 i_clk = ~i_clk;

    // configuration copy
    longint unsigned cf_y_accel, cf_y_speed, cf_y_distance, cf_x_speed;
    logic            cf_y_direction;
    logic [15:0]     cf_x_distance;
    // tracker state
    longint unsigned tick_cnt, ramp_t, cruise_t, ramp_d, cruise_d, peak_v, x_t;
    longint          integ;
    shortint         prev_ye, prev_xe;
    logic            y_busy, x_busy, x_rev, y_dir;
    logic [7:0]      y_drv, x_drv;
    longint unsigned y_ideal_last;

    logic [23:0] exp_result_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          items_sent = 0;
    bit          allow_idle = 1'b1;
    int          sink_stall = 0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sat16(input longint unsigned v);
        return (v > 65535) ? 65535 : v;
    endfunction

    task automatic pid_drive(input longint err, inout shortint prev,
                             input longint kp, input longint ki, input longint kd,
                             output logic [7:0] drv);
        longint e, s;
        e = err;
        if (e > 32767) e = 32767;
        if (e < -32768) e = -32768;
        s = integ + e;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        integ = s;
        s = integ * ki + e * kp + (e - longint'(prev)) * kd;
        prev = shortint'(e);
        if (s < 0) drv = 8'd0;
        else begin
            s = s >>> GFB;
            drv = (s > DMAX) ? 8'(DMAX) : 8'(s);
        end
    endtask

    task automatic plan_y();
        longint unsigned a, v, r;
        a = (cf_y_accel != 0) ? cf_y_accel : 1;
        v = (cf_y_speed != 0) ? cf_y_speed : 1;
        r = ((v * v) << (AFB - 1)) / a;
        if (cf_y_distance > 2 * r) begin
            ramp_d   = r;
            cruise_d = cf_y_distance - 2 * r;
            ramp_t   = sat16(int_sqrt(((2 * r) << AFB) / a));
            cruise_t = sat16(cruise_d / v);
            peak_v   = v << AFB;
        end else begin
            ramp_t   = sat16(int_sqrt((cf_y_distance << AFB) / a));
            cruise_t = 0;
            ramp_d   = cf_y_distance / 2;
            cruise_d = 0;
            peak_v   = (a * ramp_t) & 64'hFFFF_FFFF;
        end
        tick_cnt = 0;
        integ = 0;
        y_drv = 0;
        y_ideal_last = 0;
        if (cf_y_direction) y_dir = 1'b1;
        y_busy = 1'b1;
    endtask

    task automatic plan_x();
        longint d;
        longint unsigned s;
        d = longint'($signed(cf_x_distance));
        s = (cf_x_speed != 0) ? cf_x_speed : 1;
        x_t = longint'(d < 0 ? -d : d) / s;
        x_rev = (d < 0);
        tick_cnt = 0;
        integ = 0;
        x_drv = 0;
        x_busy = 1'b1;
    endtask

    // returns 1 when the Y move ends on this tick
    task automatic step_y(input logic [23:0] ycnt, output bit ended);
        longint unsigned t, ideal;
        longint dd, term;
        tick_cnt = (tick_cnt + 1) & 18'h3FFFF;
        t = tick_cnt;
        ended = 0;
        if (t < ramp_t) begin
            ideal = (cf_y_accel * t * t) >> (AFB + 1);
        end else if (t < ramp_t + cruise_t) begin
            ideal = ramp_d + (((t - ramp_t) * peak_v) >> AFB);
        end else if (t < 2 * ramp_t + cruise_t) begin
            dd = longint'(t - ramp_t - cruise_t);
            term = (2 * longint'(peak_v) - longint'(cf_y_accel) * dd) * dd;
            if (term < 0) term = 0;
            ideal = ramp_d + cruise_d + (longint'(term) >> (AFB + 1));
        end else begin
            y_busy = 1'b0;
            y_drv = 0;
            ended = 1;
        end
        if (!ended) begin
            y_ideal_last = ideal;
            pid_drive(longint'(ideal) - longint'(ycnt), prev_ye, KYP, KYI, KYD, y_drv);
        end
    endtask

    task automatic step_x(input logic [15:0] xcnt);
        longint ideal, err, xc;
        tick_cnt = (tick_cnt + 1) & 18'h3FFFF;
        if (tick_cnt >= x_t) begin
            x_busy = 1'b0;
            x_drv = 0;
        end else begin
            xc = longint'($signed(xcnt));
            ideal = longint'((cf_x_speed != 0) ? cf_x_speed : 1) * longint'(tick_cnt);
            err = x_rev ? ideal + xc : ideal - xc;
            pid_drive(err, prev_xe, KXP, KXI, KXD, x_drv);
        end
    endtask

    task automatic predict_outputs(input logic [1:0] cmd, input logic [23:0] ycnt,
                                   input logic [15:0] xcnt);
        bit clr, ended;
        clr = 0;
        if (cmd == tpt_pkg::CMD_START_Y) begin
            plan_y();
            clr = 1;
        end else if (cmd == tpt_pkg::CMD_START_X) begin
            plan_x();
            clr = 1;
        end else if (cmd == tpt_pkg::CMD_TICK) begin
            if (y_busy) begin
                step_y(ycnt, ended);
                if (ended) clr = 1;
            end
            if (x_busy) step_x(xcnt);
        end
        exp_result_q.push_back({3'b000, clr, y_dir, x_rev, x_busy, y_busy, x_drv, y_drv});
    endtask

    task automatic report(input string field, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
        mismatches++;
    endtask

    task automatic check_result(input logic [23:0] got, input logic [23:0] want);
        if (got[7:0] !== want[7:0]) report("y_drive", got[7:0], want[7:0]);
        if (got[15:8] !== want[15:8]) report("x_drive", got[15:8], want[15:8]);
        if (got[16] !== want[16]) report("y_busy", got[16], want[16]);
        if (got[17] !== want[17]) report("x_busy", got[17], want[17]);
        if (got[18] !== want[18]) report("x_reverse", got[18], want[18]);
        if (got[19] !== want[19]) report("y_dir_pin", got[19], want[19]);
        if (got[20] !== want[20]) report("clear_counts", got[20], want[20]);
        if (got[23:21] !== want[23:21]) report("pad", got[23:21], want[23:21]);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (exp_result_q.size() == 0) report("unexpected result", o_m_axis_tdata, 0);
            else check_result(o_m_axis_tdata, exp_result_q.pop_front());
        end
    end

    // sink stalls in bursts
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            i_m_axis_tready <= 1'b0;
        end else if (allow_idle && $urandom_range(0, 5) == 0) begin
            sink_stall <= $urandom_range(0, 3);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("trapezoid_profile_pid_tracker_top test failed");
            $finish;
        end
    end

    task automatic send_req(input logic [1:0] cmd, input logic [23:0] ycnt,
                            input logic [15:0] xcnt);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {xcnt, ycnt};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_outputs(cmd, ycnt, xcnt);
        items_sent++;
        // drop valid so the accepted request is not taken twice
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (exp_result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            tpt_pkg::REG_Y_ACCEL:     cf_y_accel = val[15:0];
            tpt_pkg::REG_Y_SPEED:     cf_y_speed = val[7:0];
            tpt_pkg::REG_Y_DISTANCE:  cf_y_distance = val;
            tpt_pkg::REG_Y_DIRECTION: cf_y_direction = val[0];
            tpt_pkg::REG_X_SPEED:     cf_x_speed = val[7:0];
            tpt_pkg::REG_X_DISTANCE:  cf_x_distance = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_y(input logic [15:0] a, input logic [7:0] v, input logic [23:0] d,
                         input logic dir);
        write_reg(tpt_pkg::REG_Y_ACCEL, {8'd0, a});
        write_reg(tpt_pkg::REG_Y_SPEED, {16'd0, v});
        write_reg(tpt_pkg::REG_Y_DISTANCE, d);
        write_reg(tpt_pkg::REG_Y_DIRECTION, {23'd0, dir});
    endtask

    task automatic set_x(input logic [7:0] v, input logic [15:0] d);
        write_reg(tpt_pkg::REG_X_SPEED, {16'd0, v});
        write_reg(tpt_pkg::REG_X_DISTANCE, {8'd0, d});
    endtask

    // Y count near the last ideal position, sometimes anything
    function automatic logic [23:0] pick_ycnt();
        longint v;
        if ($urandom_range(0, 9) == 0) return 24'($urandom);
        v = longint'(y_ideal_last) + longint'(cf_y_speed) + $urandom_range(0, 40) - 20;
        if (v < 0) v = 0;
        return 24'(v);
    endfunction

    function automatic logic [15:0] pick_xcnt();
        longint v;
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        v = longint'(cf_x_speed) * longint'(tick_cnt) + $urandom_range(0, 40) - 20;
        return x_rev ? 16'(-v) : 16'(v);
    endfunction

    task automatic run_ticks(input int n);
        repeat (n) send_req(tpt_pkg::CMD_TICK, pick_ycnt(), pick_xcnt());
    endtask

    task automatic test_y_profiles();
        // trapezoid with cruise
        set_y(16'd4096, 8'd4, 24'd60, 1'b0);
        send_req(tpt_pkg::CMD_TICK, 24'd0, 16'd0);
        send_req(tpt_pkg::CMD_START_Y, 24'd0, 16'd0);
        run_ticks(14);
        drain();
        // triangle, direction pin, zero accel and speed
        set_y(16'd0, 8'd0, 24'd3, 1'b1);
        send_req(tpt_pkg::CMD_START_Y, 24'hFFFFFF, 16'd0);
        send_req(tpt_pkg::CMD_TICK, 24'hFFFFFF, 16'h7FFF);
        send_req(CMD_NONE, 24'hFFFFFF, 16'h8000);
        run_ticks(3);
        drain();
        // plan overflow, then restart mid-move
        set_y(16'd1, 8'd255, 24'hFFFFFF, 1'b0);
        send_req(tpt_pkg::CMD_START_Y, 24'd0, 16'd0);
        send_req(tpt_pkg::CMD_TICK, 24'd0, 16'd0);
        set_y(16'hFFFF, 8'd255, 24'd0, 1'b0);
        send_req(tpt_pkg::CMD_START_Y, 24'd0, 16'd0);
        send_req(tpt_pkg::CMD_TICK, 24'd0, 16'd0);
        drain();
    endtask

    task automatic test_x_moves();
        set_x(8'd255, 16'h8000);
        send_req(tpt_pkg::CMD_START_X, 24'd0, 16'd0);
        send_req(tpt_pkg::CMD_TICK, 24'd0, 16'h7FFF);
        send_req(tpt_pkg::CMD_TICK, 24'd0, 16'h8000);
        drain();
        set_x(8'd0, 16'h7FFF);
        send_req(tpt_pkg::CMD_START_X, 24'd0, 16'd0);
        send_req(tpt_pkg::CMD_TICK, 24'd0, 16'h8000);
        drain();
        // shorter than one tick
        set_x(8'd50, 16'd20);
        send_req(tpt_pkg::CMD_START_X, 24'd0, 16'd0);
        send_req(tpt_pkg::CMD_TICK, 24'd0, 16'd0);
        drain();
    endtask

    task automatic test_both_axes();
        set_y(16'd8192, 8'd3, 24'd40, 1'b0);
        set_x(8'd2, 16'hFFE0);
        send_req(tpt_pkg::CMD_START_Y, 24'd0, 16'd0);
        send_req(tpt_pkg::CMD_START_X, 24'd0, 16'd0);
        run_ticks(10);
        drain();
    endtask

    task automatic test_random();
        int n, k;
        while (items_sent < RANDOM_ITEMS - 30) begin
            if (items_sent > RANDOM_ITEMS - 130) allow_idle = 1'b0;
            drain();
            if ($urandom_range(0, 7) == 0)
                set_y(16'($urandom), 8'($urandom), 24'($urandom), 1'($urandom));
            else
                set_y(16'($urandom_range(1500, 65535)), 8'($urandom_range(1, 40)),
                      24'($urandom_range(0, 3000)), ($urandom_range(0, 15) == 0));
            if ($urandom_range(0, 7) == 0)
                set_x(8'($urandom), 16'($urandom));
            else
                set_x(8'($urandom_range(1, 40)), 16'($urandom_range(0, 1600) - 800));
            k = $urandom_range(0, 3);
            if (k != 1) send_req(tpt_pkg::CMD_START_Y, pick_ycnt(), pick_xcnt());
            if (k != 0) send_req(tpt_pkg::CMD_START_X, pick_ycnt(), pick_xcnt());
            n = 0;
            while ((y_busy || x_busy) && n < 60) begin
                case ($urandom_range(0, 19))
                    0: send_req(CMD_NONE, 24'($urandom), 16'($urandom));
                    1: send_req(tpt_pkg::CMD_START_Y, pick_ycnt(), pick_xcnt());
                    2: send_req(tpt_pkg::CMD_START_X, pick_ycnt(), pick_xcnt());
                    default: send_req(tpt_pkg::CMD_TICK, pick_ycnt(), pick_xcnt());
                endcase
                n++;
            end
            send_req(tpt_pkg::CMD_TICK, pick_ycnt(), pick_xcnt());
        end
    endtask

    initial begin
        cf_y_accel = tpt_pkg::Y_ACCEL_RST; cf_y_speed = tpt_pkg::Y_SPEED_RST;
        cf_y_distance = 0; cf_y_direction = 0;
        cf_x_speed = tpt_pkg::X_SPEED_RST; cf_x_distance = 0;
        tick_cnt = 0; ramp_t = 0; cruise_t = 0; ramp_d = 0; cruise_d = 0;
        peak_v = 0; x_t = 0; integ = 0; prev_ye = 0; prev_xe = 0;
        y_busy = 0; x_busy = 0; x_rev = 0; y_dir = 0; y_drv = 0; x_drv = 0;
        y_ideal_last = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset values before any write
        send_req(tpt_pkg::CMD_START_Y, 24'd0, 16'd0);
        send_req(tpt_pkg::CMD_TICK, 24'd0, 16'd0);
        drain();
        test_y_profiles();
        test_x_moves();
        test_both_axes();
        test_random();
        drain();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && exp_result_q.size() == 0) begin
            $display("trapezoid_profile_pid_tracker_top test passed");
        end else begin
            $display("trapezoid_profile_pid_tracker_top test failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/tpt_pkg.sv
sv/tpt_mul.sv
sv/tpt_div.sv
sv/tpt_sqrt.sv
sv/trapezoid_profile_pid_tracker_top.sv
tb/tb_trapezoid_profile_pid_tracker_top.sv
